/* rtl/sha256_message_digest_macros.svh */
// assertion macros for the sha-256 digest block
// used by the top level only
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* rtl/sha_pkg.sv */
// shared types, constants and functions of the sha-256 digest block
// no dependencies
package sha_pkg;
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       final_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       place;      // write a byte into the block
    logic [7:0] pbyte;
    logic       use_pad;    // write pad byte at fill position
    logic       zero_tail;  // clear words after the pad byte
    logic       zero_all;
    logic       put_len;
    logic       count_inc;
    logic       start;      // load working vars and schedule
    logic       round;
    logic [5:0] rnd;
    logic       fold;       // add working vars into chaining words
    logic       reinit;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

/* rtl/sha_if.sv */
// valid/ready channel interface carrying one word
// depends on nothing beyond the payload type given
interface sha_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sha_datapath.sv */
// datapath: block store, schedule window, working vars, chaining words
// uses sha_pkg
module sha_datapath import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);
  logic [31:0] blk_r [16];
  logic [31:0] win_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [60:0] cnt_r;
  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [7:0]  b;
  logic [31:0] w, t1, t2, s0, s1, wn;
  logic [63:0] bits;

  assign pos = cnt_r[5:0];
  assign stat.pos = pos;
  assign wi = pos[5:2];
  assign sh = {~pos[1:0], 3'b000};
  assign b = cmd.use_pad ? PAD_BYTE : cmd.pbyte;
  assign bits = {cnt_r, 3'b000};
  assign rd_word = h_r[rd_idx];

  // window shifts each round: element 0 is the current schedule word
  always_comb begin
    s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    wn = s1 + win_r[9] + s0 + win_r[0];
    w = win_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[cmd.rnd] + w;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.place || cmd.use_pad) begin
      if (pos[1:0] == 2'd0) blk_r[wi] <= {24'd0, b} << sh;
      else blk_r[wi] <= blk_r[wi] | ({24'd0, b} << sh);
    end
    if (cmd.zero_tail) begin
      for (int i = 0; i < 16; i++) if (4'(i) > wi) blk_r[i] <= '0;
    end
    if (cmd.zero_all) begin
      for (int i = 0; i < 16; i++) blk_r[i] <= '0;
    end
    if (cmd.put_len) begin
      blk_r[14] <= bits[63:32];
      blk_r[15] <= bits[31:0];
    end
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) win_r[i] <= blk_r[i];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      // the word pulled in feeds round rnd+16
      win_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      cnt_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.count_inc) cnt_r <= cnt_r + 61'd1;
    end
  end
endmodule

/* rtl/sha_ctrl.sv */
// controller: byte intake, padding sequence, round counter, digest output
// uses sha_pkg
module sha_ctrl import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_idx,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD   = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_RND   = 8'b0000_1000,
    S_FOLD  = 8'b0001_0000,
    S_ZERO  = 8'b0010_0000,
    S_LEN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;  // finishing pass pending
  logic       two_r, two_nxt;  // padding needs an extra block
  logic       acc;
  // a closing block is being folded when the last step was a length write
  logic       len_done_r;

  assign in_ready = (st_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (st_r == S_OUT);
  assign out_idx = idx_r;

  always_comb begin
    st_nxt = st_r; rnd_nxt = rnd_r; idx_nxt = idx_r;
    fin_nxt = fin_r; two_nxt = two_r;
    cmd = '0;
    cmd.pbyte = in_data.message_byte;
    cmd.rnd = rnd_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          fin_nxt = in_data.final_item;
          if (in_data.byte_present) begin
            cmd.place = 1'b1;
            cmd.count_inc = 1'b1;
            if (stat.pos == 6'd63) st_nxt = S_START;
            else if (in_data.final_item) st_nxt = S_PAD;
          end else if (in_data.final_item) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.use_pad = 1'b1;
        cmd.zero_tail = 1'b1;
        two_nxt = (stat.pos >= 6'd56);
        fin_nxt = 1'b0;
        st_nxt = (stat.pos >= 6'd56) ? S_START : S_LEN;
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        two_nxt = 1'b0;
        st_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        rnd_nxt = '0;
        st_nxt = S_RND;
      end
      S_RND: begin
        cmd.round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        idx_nxt = '0;
        // fin_r: message block that ended with the final mark
        if (fin_r) st_nxt = S_PAD;
        else if (two_r) st_nxt = S_ZERO;
        else if (len_done_r) st_nxt = S_OUT;
        else st_nxt = S_IDLE;
      end
      S_ZERO: begin
        cmd.zero_all = 1'b1;
        st_nxt = S_LEN;
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reinit = 1'b1;
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rnd_r <= '0; idx_r <= '0;
      fin_r <= 1'b0; two_r <= 1'b0; len_done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; idx_r <= idx_nxt;
      fin_r <= fin_nxt; two_r <= two_nxt;
      if (st_r == S_LEN) len_done_r <= 1'b1;
      else if (st_r == S_FOLD) len_done_r <= 1'b0;
    end
  end
endmodule

/* rtl/sha256_message_digest.sv */
// channel  | dir | payload
// in_      | in  | message_byte, byte_present, final_item
// out_     | out | digest_word, word_index, last_word
// a byte is accepted on each handshake; a full block then passes through the
// single shared round unit (load, 64 rounds, fold). a final item adds the
// padding steps and one or two blocks, then eight output words.
// input is held off while rounds run or the digest is out; output stalls
// simply hold the current word. reset is synchronous, active low.
`include "sha256_message_digest_macros.svh"
module sha256_message_digest import sha_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  sha_if.sink   in_ch,
  sha_if.source out_ch
);
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] idx;
  logic [31:0] word;
  in_item_t   in_item;
  out_item_t  out_item;

  assign in_item = in_ch.data;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_idx(idx),
    .cmd(cmd), .stat(stat));

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .rd_idx(idx), .rd_word(word));

  always_comb begin
    out_item.digest_word = word;
    out_item.word_index = idx;
    out_item.last_word = (idx == 3'd7);
  end
  assign out_ch.data = out_item;

  `SHA_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid, "in and out both open")
  `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n, out_ch.valid && out_ch.ready && idx != 3'd7, out_ch.valid && idx == $past(idx) + 3'd1, "word index skipped")
  `SHA_ASSERT_IMPL(a_round_excl, clk, rst_n, cmd.round, !cmd.start && !cmd.fold, "round overlaps load")
endmodule
